[hdl/dma_source_chain_tag_sequencer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the chain tag sequencer controller.
// All checks are sampled on the rising edge of clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DMA_SOURCE_CHAIN_TAG_SEQUENCER_UNIT_DEFINES_SVH
`define DMA_SOURCE_CHAIN_TAG_SEQUENCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dcts_pkg.sv]
// ----------------------------------------------------------------------------
// dcts_pkg
// Types, codes and sizes shared by the chain tag sequencer modules.
// ----------------------------------------------------------------------------
package dcts_pkg;

    // Quadwords moved by one service tick at most.
    localparam int BURST_QWORDS = 8;
    localparam int CHUNK_W      = $clog2(BURST_QWORDS + 1);

    // Port widths.
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Input item functions.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_TAG   = 2'd2;

    // Channel modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CHAIN  = 2'd1;

    // Result kinds.
    localparam logic [2:0] KIND_TAG     = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_IRQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_ADDR  = 3'd4;

    // What the item at the input asks for, given the current channel state.
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_START       = 3'd1;
    localparam logic [2:0] ACT_DECODE      = 3'd2;
    localparam logic [2:0] ACT_TAG_FAULT   = 3'd3;
    localparam logic [2:0] ACT_TAG_REQ     = 3'd4;
    localparam logic [2:0] ACT_BURST_FAULT = 3'd5;
    localparam logic [2:0] ACT_BURST       = 3'd6;
    localparam logic [2:0] ACT_DONE        = 3'd7;

    // Controller to datapath.
    typedef struct packed {
        logic       accept;
        logic       load_out;
        logic [2:0] out_kind;
        logic       out_last;
        logic       burst_step;
        logic       finish;
    } dcts_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] action;
        logic       out_free;
        logic       burst_last;
        logic       done_due;
    } dcts_status_t;

endpackage

[hdl/dcts_datapath.sv]
// ----------------------------------------------------------------------------
// dcts_datapath
// Channel state, configuration registers, tag decode, burst address
// generation and the result register.
// ----------------------------------------------------------------------------
module dcts_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcts_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [dcts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [dcts_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dcts_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [dcts_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast,
    input  dcts_pkg::dcts_cmd_t              cmd,
    output dcts_pkg::dcts_status_t           status
);
    import dcts_pkg::*;

    // Chain tag identifiers.
    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;
    localparam logic [2:0] TAG_REFS = 3'd4;
    localparam logic [2:0] TAG_END  = 3'd7;

    localparam logic [31:0] QW_BYTES = 32'd16;

    // Map a source address: scratchpad window or plain quadword address.
    function automatic logic [31:0] map_addr(input logic [31:0] a, input logic scratch);
        if (scratch)
            return 32'h7000_0000 | (a & 32'h0000_3FF0);
        else
            return a & 32'h7FFF_FFF0;
    endfunction

    // Configuration registers.
    logic [1:0]  cfg_mode_reg;
    logic        cfg_tie_reg;
    logic [31:0] cfg_addr_reg;
    logic [15:0] cfg_count_reg;
    logic [31:0] cfg_tadr_reg;

    // Channel state.
    logic        running_reg, running_next;
    logic [31:0] pa_reg, pa_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] nta_reg, nta_next;
    logic        ending_reg, ending_next;
    logic        awaiting_reg, awaiting_next;
    logic [15:0] upper_reg, upper_next;
    logic [1:0]  mode_reg, mode_next;

    // Burst and error bookkeeping.
    logic [31:0]        burst_addr_reg, burst_addr_next;
    logic               scratch_reg, scratch_next;
    logic [CHUNK_W-1:0] burst_cnt_reg, burst_cnt_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [31:0]        err_addr_reg, err_addr_next;

    // Result register.
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [2:0]         m_kind_reg;
    logic               m_last_reg;

    // Input item fields.
    logic [1:0]  in_func;
    logic        in_enable;
    logic [63:0] in_word;
    logic        in_fault;

    assign in_func   = s_axis_tuser;
    assign in_enable = s_axis_tdata[0];
    assign in_word   = s_axis_tdata[64:1];
    assign in_fault  = s_axis_tdata[65];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode_reg  <= '0;
            cfg_tie_reg   <= 1'b0;
            cfg_addr_reg  <= '0;
            cfg_count_reg <= '0;
            cfg_tadr_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:     cfg_mode_reg  <= cfg_data[1:0];
                CFG_TAG_IRQ:  cfg_tie_reg   <= cfg_data[0];
                CFG_ADDRESS:  cfg_addr_reg  <= cfg_data;
                CFG_COUNT:    cfg_count_reg <= cfg_data[15:0];
                CFG_TAG_ADDR: cfg_tadr_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Classify the item waiting at the input against the channel state.
    logic [2:0] action;

    always_comb
    begin
        action = ACT_NONE;
        case (in_func)
            FUNC_START: action = ACT_START;
            FUNC_TAG:
            begin
                if (awaiting_reg)
                    action = in_fault ? ACT_TAG_FAULT : ACT_DECODE;
            end
            FUNC_TICK:
            begin
                if (in_enable && running_reg && !mode_reg[1] && !awaiting_reg)
                begin
                    if (mode_reg == MODE_CHAIN && count_reg == '0 && !ending_reg)
                        action = ACT_TAG_REQ;
                    else if (count_reg != '0)
                        action = in_fault ? ACT_BURST_FAULT : ACT_BURST;
                    else
                        action = ACT_DONE;
                end
            end
            default: action = ACT_NONE;
        endcase
    end

    // Tag decode.
    logic [31:0] t0, t1;
    logic [2:0]  tag_id;
    logic [31:0] tag_addr;
    logic [31:0] tag_after;
    logic [15:0] tag_count;

    assign t0        = in_word[31:0];
    assign t1        = in_word[63:32];
    assign tag_id    = t0[30:28];
    assign tag_count = t0[15:0];
    assign tag_addr  = map_addr(t1, t1[31]);
    assign tag_after = (nta_reg & 32'h7FFF_FFF0) + QW_BYTES;

    // Burst size of this tick.
    logic [CHUNK_W-1:0] chunk;

    assign chunk = (count_reg < 16'(BURST_QWORDS)) ? CHUNK_W'(count_reg)
                                                   : CHUNK_W'(BURST_QWORDS);

    // Next channel state.
    always_comb
    begin
        running_next    = running_reg;
        pa_next         = pa_reg;
        count_next      = count_reg;
        nta_next        = nta_reg;
        ending_next     = ending_reg;
        awaiting_next   = awaiting_reg;
        upper_next      = upper_reg;
        mode_next       = mode_reg;
        burst_addr_next = burst_addr_reg;
        scratch_next    = scratch_reg;
        burst_cnt_next  = burst_cnt_reg;
        chunk_next      = chunk_reg;
        err_addr_next   = err_addr_reg;

        if (cmd.accept)
        begin
            case (action)
                ACT_START:
                begin
                    pa_next       = cfg_addr_reg;
                    count_next    = cfg_count_reg;
                    nta_next      = cfg_tadr_reg;
                    mode_next     = cfg_mode_reg;
                    running_next  = 1'b1;
                    awaiting_next = 1'b0;
                end
                ACT_TAG_FAULT:
                begin
                    awaiting_next = 1'b0;
                    err_addr_next = pa_reg;
                end
                ACT_DECODE:
                begin
                    awaiting_next = 1'b0;
                    count_next    = tag_count;
                    upper_next    = t0[31:16];
                    ending_next   = (tag_id == TAG_REFE) || (tag_id == TAG_END) ||
                                    (t0[31] && cfg_tie_reg);
                    case (tag_id)
                        TAG_REFE, TAG_REF, TAG_REFS:
                        begin
                            pa_next  = tag_addr;
                            nta_next = tag_after;
                        end
                        TAG_CNT, TAG_END:
                        begin
                            pa_next  = tag_after;
                            nta_next = tag_after + (32'(tag_count) << 4);
                        end
                        TAG_NEXT:
                        begin
                            pa_next  = tag_after;
                            nta_next = tag_addr;
                        end
                        default:
                        begin
                            // Call and return tags finish after their payload.
                            pa_next     = tag_after;
                            nta_next    = tag_addr;
                            ending_next = 1'b1;
                        end
                    endcase
                end
                ACT_TAG_REQ: awaiting_next = 1'b1;
                ACT_BURST_FAULT: err_addr_next = map_addr(pa_reg, pa_reg[31]);
                ACT_BURST:
                begin
                    count_next      = count_reg - 16'(chunk);
                    pa_next         = pa_reg + (32'(chunk) << 4);
                    burst_addr_next = pa_reg;
                    scratch_next    = pa_reg[31];
                    burst_cnt_next  = '0;
                    chunk_next      = chunk;
                end
                default: ;
            endcase
        end

        // One payload address goes out per step.
        if (cmd.burst_step)
        begin
            burst_cnt_next  = burst_cnt_reg + CHUNK_W'(1);
            burst_addr_next = burst_addr_reg + QW_BYTES;
        end

        // The done result stops the channel.
        if (cmd.finish)
        begin
            running_next = 1'b0;
            ending_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            pa_reg       <= '0;
            count_reg    <= '0;
            nta_reg      <= '0;
            ending_reg   <= 1'b0;
            awaiting_reg <= 1'b0;
            upper_reg    <= '0;
            mode_reg     <= '0;
        end
        else
        begin
            running_reg  <= running_next;
            pa_reg       <= pa_next;
            count_reg    <= count_next;
            nta_reg      <= nta_next;
            ending_reg   <= ending_next;
            awaiting_reg <= awaiting_next;
            upper_reg    <= upper_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_addr_reg <= burst_addr_next;
        scratch_reg    <= scratch_next;
        burst_cnt_reg  <= burst_cnt_next;
        chunk_reg      <= chunk_next;
        err_addr_reg   <= err_addr_next;
    end

    // Address of the result being loaded.
    logic [31:0] out_addr;

    always_comb
    begin
        case (cmd.out_kind)
            KIND_TAG:     out_addr = nta_reg & 32'h7FFF_FFF0;
            KIND_PAYLOAD: out_addr = map_addr(burst_addr_reg, scratch_reg);
            KIND_DONE:    out_addr = pa_reg;
            default:      out_addr = err_addr_reg;
        endcase
    end

    // Result register: holds one item until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.load_out)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_data_reg <= {upper_reg, count_reg, out_addr};
            m_kind_reg <= cmd.out_kind;
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    // Status toward the controller.
    assign status.action     = action;
    assign status.out_free   = !m_valid_reg || m_axis_tready;
    assign status.burst_last = (burst_cnt_reg + CHUNK_W'(1)) == chunk_reg;
    assign status.done_due   = (count_reg == '0) && ((mode_reg == MODE_NORMAL) || ending_reg);

endmodule

[hdl/dcts_ctrl.sv]
// ----------------------------------------------------------------------------
// dcts_ctrl
// Accepts items and steps out their results one per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "dma_source_chain_tag_sequencer_unit_defines.svh"

module dcts_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  dcts_pkg::dcts_status_t status,
    output dcts_pkg::dcts_cmd_t    cmd
);
    import dcts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAG   = 3'd1;
    localparam logic [2:0] ST_ERR   = 3'd2;
    localparam logic [2:0] ST_BURST = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_kind   = KIND_ERROR;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    case (status.action)
                        ACT_TAG_FAULT, ACT_BURST_FAULT: state_next = ST_ERR;
                        ACT_TAG_REQ:                    state_next = ST_TAG;
                        ACT_BURST:                      state_next = ST_BURST;
                        ACT_DONE:                       state_next = ST_DONE;
                        default:                        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TAG:
            begin
                cmd.out_kind = KIND_TAG;
                cmd.out_last = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                cmd.out_kind = KIND_ERROR;
                cmd.out_last = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BURST:
            begin
                cmd.out_kind = KIND_PAYLOAD;
                cmd.out_last = status.burst_last && !status.done_due;
                if (status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.burst_step = 1'b1;
                    if (status.burst_last)
                        state_next = status.done_due ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                cmd.out_kind = KIND_DONE;
                cmd.out_last = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks on the sequencing.
    `DCTS_ASSERT_SAME(a_load_when_free, cmd.load_out, status.out_free, "result loaded over a waiting one")
    `DCTS_ASSERT_SAME(a_no_load_on_accept, cmd.accept, !cmd.load_out, "result loaded while accepting an item")
    `DCTS_ASSERT_NEXT(a_burst_ends, (state_reg == ST_BURST) && cmd.load_out && status.burst_last, state_reg != ST_BURST, "burst ran past its last address")
    `DCTS_ASSERT_NEXT(a_last_to_idle, cmd.load_out && cmd.out_last, state_reg == ST_IDLE, "sequencer busy after last result")

endmodule

[hdl/dma_source_chain_tag_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// dma_source_chain_tag_sequencer_unit
// DMA source channel that walks chain tags and issues quadword addresses.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries start, service tick and tag delivered items.
//   The output channel returns tag fetches, payload addresses, done and
//   error results; tlast marks the final result of one input item.
//   The configuration channel writes mode, tag interrupt enable, start
//   address, start count and start tag address; it is always ready. The user
//   must write it only while the block is idle; this is not enforced.
// Timing:
//   An item is taken only while the sequencer is idle. Starts, tag
//   decodes and ignored items give no result. Other ticks then give one
//   result per cycle while the receiver keeps up, at most eight payload
//   addresses and a done result, the sequencer walking the burst one
//   address per cycle.
// Reset and stall:
//   Reset stops the channel; burst, error and result data are not reset. If
//   the receiver stalls, the result register holds its item and the sequencer
//   waits; no new item is taken until the current one has issued its results.
// ----------------------------------------------------------------------------
module dma_source_chain_tag_sequencer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcts_pkg::CFG_DAT_W-1:0]   cfg_data,
    // Input items.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: dmac_enable [0], tag_word [64:1], fault [65], zero [71:66]
    input  logic [dcts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: func [1:0]
    input  logic [dcts_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // Result items.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: address [31:0], remaining_qwords [47:32], tag_control_bits [63:48]
    output logic [dcts_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: kind [2:0]
    output logic [dcts_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import dcts_pkg::*;

    dcts_cmd_t    cmd;
    dcts_status_t status;

    // Sequencer.
    dcts_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Channel state and address datapath.
    dcts_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
